[rtl/crt_pkg.sv]
// Shared constants, types and state encoding for the connection redirect table.
`default_nettype none

package crt_pkg;

    // Table geometry
    localparam int ENTRIES = 4096;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 48;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PROXY_PORT     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_ENABLE = CFG_IDX_W'(1);

    // Function codes
    localparam logic [1:0] FUNC_CONNECT  = 2'd0;
    localparam logic [1:0] FUNC_REDIRECT = 2'd1;
    localparam logic [1:0] FUNC_QUERY    = 2'd2;

    // Fixed values
    localparam logic [15:0] PROXY_PORT_RST = 16'd9529;
    localparam logic [31:0] LOOPBACK_ADDR  = 32'h7F00_0001;
    localparam logic [31:0] PID_IDLE       = 32'd0;
    localparam logic [31:0] PID_SYSTEM     = 32'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } crt_state_t;

    // Command from the sequencer to the table
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } tbl_cmd_t;

    // One result beat
    typedef struct packed {
        logic        action;
        logic        stored;
        logic        found;
        logic [31:0] orig_addr;
        logic [15:0] orig_port;
        logic        rewrite;
        logic [31:0] redirect_addr;
        logic [15:0] redirect_port;
    } res_t;

endpackage

`default_nettype wire

[rtl/crt_if.sv]
// Request, response and configuration channel interfaces.
`default_nettype none

interface crt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] process_id;
    logic        write_right;
    logic [31:0] local_addr;
    logic [15:0] local_port;
    logic [31:0] remote_addr;
    logic [15:0] remote_port;

    modport source (
        output valid, func, process_id, write_right, local_addr, local_port,
               remote_addr, remote_port,
        input  ready
    );
    modport sink (
        input  valid, func, process_id, write_right, local_addr, local_port,
               remote_addr, remote_port,
        output ready
    );
endinterface

interface crt_rsp_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic        stored;
    logic        found;
    logic [31:0] orig_addr;
    logic [15:0] orig_port;
    logic        rewrite;
    logic [31:0] redirect_addr;
    logic [15:0] redirect_port;

    modport source (
        output valid, action, stored, found, orig_addr, orig_port, rewrite,
               redirect_addr, redirect_port,
        input  ready
    );
    modport sink (
        input  valid, action, stored, found, orig_addr, orig_port, rewrite,
               redirect_addr, redirect_port,
        output ready
    );
endinterface

interface crt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [crt_pkg::CFG_IDX_W-1:0]  index;
    logic [crt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/connection_redirect_table.sv]
// Top level: sequencer, key compare, config registers and result register.
//
//  channel | dir | handshake      | beat contents
//  --------+-----+----------------+-------------------------------------------
//  req     | in  | valid / ready  | func, process_id, write_right, key, dest
//  rsp     | out | valid / ready  | action, stored, found, orig, rewrite, redir
//  cfg     | in  | valid / ready  | index (0 proxy_port, 1 capture_enable), data
//
//  Connect, redirect and unused func codes pass from exec straight to done.
//  A query scans the filled slots from slot 0 (on an empty table it goes
//  straight to done): the single table read port and key comparator visit
//  one slot per cycle behind a registered read, stopping at the first match
//  or after the last filled slot. Reset clears the fill count, which empties
//  the table at once; no clearing pass is needed. req is taken only in idle,
//  while an earlier result may still wait in the output register; a finished
//  item holds in its done state until that register frees.
`default_nettype none

module connection_redirect_table (
    input  wire logic clk,
    input  wire logic rst_n,
    crt_req_if.sink   req,
    crt_rsp_if.source rsp,
    crt_cfg_if.sink   cfg
);
    import crt_pkg::*;

    // Config registers
    logic [15:0] proxy_port_reg;
    logic        capture_enable_reg;

    // Sequencer
    crt_state_t state_reg;
    crt_state_t state_next;

    // Captured item
    logic [1:0]       func_reg;
    logic [31:0]      pid_reg;
    logic             wr_right_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] dest_reg;

    // Scan control
    logic [CNT_W-1:0] scan_addr_reg;
    logic [CNT_W-1:0] scan_addr_next;
    logic             rd_pend_reg;
    logic             rd_pend_next;

    // Results
    res_t res_reg;
    res_t res_next;
    res_t out_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    // Table connections
    tbl_cmd_t         cmd;
    logic [CNT_W-1:0] fill;
    logic [KEY_W-1:0] rd_key;
    logic [KEY_W-1:0] rd_dest;

    logic match;
    logic hit;
    logic issue;
    logic scan_end;
    logic do_store;

    crt_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .wr_key  (key_reg),
        .wr_dest (dest_reg),
        .fill    (fill),
        .rd_key  (rd_key),
        .rd_dest (rd_dest)
    );

    // Config writes land at once; unknown indexes drop.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proxy_port_reg     <= PROXY_PORT_RST;
            capture_enable_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_PROXY_PORT)
            begin
                proxy_port_reg <= cfg.data[15:0];
            end
            else if (cfg.index == CFG_CAPTURE_ENABLE)
            begin
                capture_enable_reg <= cfg.data[0];
            end
        end
    end

    // Compare the slot read last cycle against the key.
    assign match    = (rd_key == key_reg);
    assign hit      = rd_pend_reg && match;
    assign issue    = (scan_addr_reg != fill) && !hit;
    assign scan_end = rd_pend_reg && !match && (scan_addr_reg == fill);
    assign out_free = !out_valid_reg || rsp.ready;

    // Store decision for connect and redirect
    always_comb
    begin
        do_store = 1'b0;
        case (func_reg)
            FUNC_CONNECT:
            begin
                do_store = capture_enable_reg
                        && (pid_reg != PID_IDLE) && (pid_reg != PID_SYSTEM)
                        && !((dest_reg[15:0] == proxy_port_reg)
                             && (dest_reg[KEY_W-1:16] == LOOPBACK_ADDR));
            end
            FUNC_REDIRECT:
            begin
                do_store = wr_right_reg;
            end
            default:
            begin
                do_store = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((func_reg == FUNC_QUERY) && (fill != '0))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (hit || scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        req.ready      = 1'b0;
        cmd            = '0;
        res_next       = res_reg;
        scan_addr_next = scan_addr_reg;
        rd_pend_next   = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.wr_en      = do_store;
                res_next       = '0;
                res_next.action = do_store;
                res_next.stored = do_store;
                if ((func_reg == FUNC_REDIRECT) && do_store)
                begin
                    res_next.rewrite       = 1'b1;
                    res_next.redirect_addr = LOOPBACK_ADDR;
                    res_next.redirect_port = proxy_port_reg;
                end
                scan_addr_next = '0;
            end
            ST_SCAN:
            begin
                cmd.rd_en      = issue;
                cmd.rd_addr    = scan_addr_reg[IDX_W-1:0];
                scan_addr_next = scan_addr_reg + CNT_W'(issue);
                rd_pend_next   = issue;
                if (hit)
                begin
                    res_next.found     = 1'b1;
                    res_next.orig_addr = rd_dest[KEY_W-1:16];
                    res_next.orig_port = rd_dest[15:0];
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_addr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            scan_addr_reg <= scan_addr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg     <= req.func;
            pid_reg      <= req.process_id;
            wr_right_reg <= req.write_right;
            key_reg      <= {req.local_addr, req.local_port};
            dest_reg     <= {req.remote_addr, req.remote_port};
        end
        res_reg <= res_next;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.action        = out_reg.action;
    assign rsp.stored        = out_reg.stored;
    assign rsp.found         = out_reg.found;
    assign rsp.orig_addr     = out_reg.orig_addr;
    assign rsp.orig_port     = out_reg.orig_port;
    assign rsp.rewrite       = out_reg.rewrite;
    assign rsp.redirect_addr = out_reg.redirect_addr;
    assign rsp.redirect_port = out_reg.redirect_port;

endmodule

`default_nettype wire

[rtl/crt_table.sv]
// Entry memory with fill count, lowest-free-slot write (slot 0 once full) and registered read.
`default_nettype none

module crt_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire crt_pkg::tbl_cmd_t         cmd,
    input  wire logic [crt_pkg::KEY_W-1:0] wr_key,
    input  wire logic [crt_pkg::KEY_W-1:0] wr_dest,
    output logic      [crt_pkg::CNT_W-1:0] fill,
    output logic      [crt_pkg::KEY_W-1:0] rd_key,
    output logic      [crt_pkg::KEY_W-1:0] rd_dest
);
    import crt_pkg::*;

    logic [2*KEY_W-1:0] mem [ENTRIES];
    logic [2*KEY_W-1:0] rd_q_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic               full;
    logic [IDX_W-1:0]   wr_slot;

    // Entries are never freed, so the valid ones are always slots 0..fill-1.
    assign full    = (fill_reg == CNT_W'(ENTRIES));
    assign wr_slot = full ? '0 : fill_reg[IDX_W-1:0];

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.wr_en && !full)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_slot] <= {wr_key, wr_dest};
        end
        if (cmd.rd_en)
        begin
            rd_q_reg <= mem[cmd.rd_addr];
        end
    end

    assign fill    = fill_reg;
    assign rd_key  = rd_q_reg[2*KEY_W-1:KEY_W];
    assign rd_dest = rd_q_reg[KEY_W-1:0];

endmodule

`default_nettype wire
